/* hw/rtl/rgbuyvy_pkg.sv */
// ----------------------------------------------------------------------------
// rgbuyvy_pkg
// Shared constants and types for the RGB to UYVY field split converter.
// ----------------------------------------------------------------------------
package rgbuyvy_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int WORD_W  = 18;
    localparam int PAIRS_MAX = MAX_WIDTH / 2;
    localparam int COL_W   = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CNT_W   = 14;
    localparam int SUM_W   = 17;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(1024);

    // bt.601 integer matrix, magnitudes; signs are applied in the datapath
    localparam logic [SUM_W-1:0] K_YR = SUM_W'(66);
    localparam logic [SUM_W-1:0] K_YG = SUM_W'(129);
    localparam logic [SUM_W-1:0] K_YB = SUM_W'(25);
    localparam logic [SUM_W-1:0] K_UR = SUM_W'(38);
    localparam logic [SUM_W-1:0] K_UG = SUM_W'(74);
    localparam logic [SUM_W-1:0] K_UB = SUM_W'(112);
    localparam logic [SUM_W-1:0] K_VR = SUM_W'(112);
    localparam logic [SUM_W-1:0] K_VG = SUM_W'(94);
    localparam logic [SUM_W-1:0] K_VB = SUM_W'(18);
    localparam logic [SUM_W-1:0] ROUND      = SUM_W'(128);
    localparam logic [SUM_W-1:0] CHROMA_BIAS = SUM_W'(128 + 32768);
    localparam logic [PIX_W-1:0] LUMA_OFS   = PIX_W'(16);

    typedef struct packed {
        logic              odd_field;
        logic [WORD_W-1:0] word_index;
        logic              last_pair;
    } t_pos;

endpackage

/* hw/rtl/rgb_to_uyvy_field_split.sv */
// ----------------------------------------------------------------------------
// rgb_to_uyvy_field_split
// RGB pixel pair to UYVY 4:2:2 word, BT.601 matrix, split into two fields.
// ----------------------------------------------------------------------------
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------
//  pixels   | i_valid  | o_stall  | i_red/green/blue_first, .._second
//  uyvy     | o_valid  | i_stall  | o_chroma_u, o_luma_first, o_chroma_v,
//           |          |          | o_luma_second, o_odd_field,
//           |          |          | o_word_index, o_last_pair
//  config   | i_cfg_we | -        | i_cfg_index, i_cfg_data
//
//  one request per clock sustained while no held word is stalled; each accepted pair goes into the output register
//  two luma lanes and one chroma lane run in parallel, merged at the register
//  synchronous active-low reset: counters zero, geometry 1024 x 1024
//  o_stall is raised only while a held word is stalled downstream
// ----------------------------------------------------------------------------
module rgb_to_uyvy_field_split import rgbuyvy_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_red_first,
    input  logic [PIX_W-1:0]  i_green_first,
    input  logic [PIX_W-1:0]  i_blue_first,
    input  logic [PIX_W-1:0]  i_red_second,
    input  logic [PIX_W-1:0]  i_green_second,
    input  logic [PIX_W-1:0]  i_blue_second,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIX_W-1:0]  o_chroma_u,
    output logic [PIX_W-1:0]  o_luma_first,
    output logic [PIX_W-1:0]  o_chroma_v,
    output logic [PIX_W-1:0]  o_luma_second,
    output logic              o_odd_field,
    output logic [WORD_W-1:0] o_word_index,
    output logic              o_last_pair
);

    logic              r_valid;
    logic [PIX_W-1:0]  r_chroma_u;
    logic [PIX_W-1:0]  r_luma_first;
    logic [PIX_W-1:0]  r_chroma_v;
    logic [PIX_W-1:0]  r_luma_second;
    t_pos              r_pos;

    logic              accept;
    logic [PIX_W-1:0]  luma0;
    logic [PIX_W-1:0]  luma1;
    logic [PIX_W-1:0]  chroma_u;
    logic [PIX_W-1:0]  chroma_v;
    t_pos              pos;

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    rgbuyvy_luma u_luma0 (
        .i_red   (i_red_first),
        .i_green (i_green_first),
        .i_blue  (i_blue_first),
        .o_luma  (luma0)
    );

    rgbuyvy_luma u_luma1 (
        .i_red   (i_red_second),
        .i_green (i_green_second),
        .i_blue  (i_blue_second),
        .o_luma  (luma1)
    );

    rgbuyvy_chroma u_chroma (
        .i_red      (i_red_first),
        .i_green    (i_green_first),
        .i_blue     (i_blue_first),
        .o_chroma_u (chroma_u),
        .o_chroma_v (chroma_v)
    );

    rgbuyvy_pos u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (accept),
        .o_pos       (pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chroma_u    <= chroma_u;
            r_luma_first  <= luma0;
            r_chroma_v    <= chroma_v;
            r_luma_second <= luma1;
            r_pos         <= pos;
        end
    end

    assign o_valid       = r_valid;
    assign o_chroma_u    = r_chroma_u;
    assign o_luma_first  = r_luma_first;
    assign o_chroma_v    = r_chroma_v;
    assign o_luma_second = r_luma_second;
    assign o_odd_field   = r_pos.odd_field;
    assign o_word_index  = r_pos.word_index;
    assign o_last_pair   = r_pos.last_pair;

endmodule

/* hw/rtl/rgbuyvy_luma.sv */
// ----------------------------------------------------------------------------
// rgbuyvy_luma
// Luma lane: Y of one pixel with rounding and offset.
// ----------------------------------------------------------------------------
module rgbuyvy_luma import rgbuyvy_pkg::*; (
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic [PIX_W-1:0] o_luma
);

    logic [SUM_W-1:0] sum;

    assign sum = K_YR * SUM_W'(i_red) + K_YG * SUM_W'(i_green)
               + K_YB * SUM_W'(i_blue) + ROUND;
    assign o_luma = sum[PIX_W+7:8] + LUMA_OFS;

endmodule

/* hw/rtl/rgbuyvy_chroma.sv */
// ----------------------------------------------------------------------------
// rgbuyvy_chroma
// Chroma lane: U and V of the left pixel with rounding and offset.
// ----------------------------------------------------------------------------
module rgbuyvy_chroma import rgbuyvy_pkg::*; (
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic [PIX_W-1:0] o_chroma_u,
    output logic [PIX_W-1:0] o_chroma_v
);

    logic [SUM_W-1:0] sum_u;
    logic [SUM_W-1:0] sum_v;

    // bias keeps the sum positive, so bits above the byte carry the offset
    assign sum_u = K_UB * SUM_W'(i_blue) + CHROMA_BIAS
                 - K_UR * SUM_W'(i_red) - K_UG * SUM_W'(i_green);
    assign sum_v = K_VR * SUM_W'(i_red) + CHROMA_BIAS
                 - K_VG * SUM_W'(i_green) - K_VB * SUM_W'(i_blue);

    assign o_chroma_u = sum_u[PIX_W+7:8];
    assign o_chroma_v = sum_v[PIX_W+7:8];

endmodule

/* hw/rtl/rgbuyvy_pos.sv */
// ----------------------------------------------------------------------------
// rgbuyvy_pos
// Frame geometry registers and raster position / field word counters.
// ----------------------------------------------------------------------------
module rgbuyvy_pos import rgbuyvy_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_advance,
    output t_pos             o_pos
);

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [COL_W-1:0]  r_pair_column,  n_pair_column;
    logic [ROW_W-1:0]  r_row_number,   n_row_number;
    logic [WORD_W-1:0] r_even_words,   n_even_words;
    logic [WORD_W-1:0] r_odd_words,    n_odd_words;

    logic [CNT_W-1:0] pairs_raw;
    logic [CNT_W-1:0] pairs;
    logic [CNT_W-1:0] rows;
    logic             odd;
    logic             row_end;
    logic             frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturated and zero-guarded geometry
    always_comb begin
        pairs_raw = (CNT_W'(r_frame_width) + CNT_W'(1)) >> 1;
        if (pairs_raw > CNT_W'(PAIRS_MAX)) begin
            pairs = CNT_W'(PAIRS_MAX);
        end else if (pairs_raw == '0) begin
            pairs = CNT_W'(1);
        end else begin
            pairs = pairs_raw;
        end
        if (CNT_W'(r_frame_height) > CNT_W'(MAX_HEIGHT)) begin
            rows = CNT_W'(MAX_HEIGHT);
        end else if (r_frame_height == '0) begin
            rows = CNT_W'(1);
        end else begin
            rows = CNT_W'(r_frame_height);
        end
    end

    assign odd       = r_row_number[0];
    assign row_end   = (CNT_W'(r_pair_column) + CNT_W'(1)) >= pairs;
    assign frame_end = row_end && ((CNT_W'(r_row_number) + CNT_W'(1)) >= rows);

    always_comb begin
        n_pair_column = r_pair_column;
        n_row_number  = r_row_number;
        n_even_words  = r_even_words;
        n_odd_words   = r_odd_words;
        if (frame_end) begin
            n_pair_column = '0;
            n_row_number  = '0;
            n_even_words  = '0;
            n_odd_words   = '0;
        end else begin
            if (odd) begin
                n_odd_words = r_odd_words + WORD_W'(1);
            end else begin
                n_even_words = r_even_words + WORD_W'(1);
            end
            if (row_end) begin
                n_pair_column = '0;
                n_row_number  = r_row_number + ROW_W'(1);
            end else begin
                n_pair_column = r_pair_column + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_column <= '0;
            r_row_number  <= '0;
            r_even_words  <= '0;
            r_odd_words   <= '0;
        end else if (i_advance) begin
            r_pair_column <= n_pair_column;
            r_row_number  <= n_row_number;
            r_even_words  <= n_even_words;
            r_odd_words   <= n_odd_words;
        end
    end

    assign o_pos.odd_field  = odd;
    assign o_pos.word_index = odd ? r_odd_words : r_even_words;
    assign o_pos.last_pair  = frame_end;

endmodule

/* bench/tb_rgb_to_uyvy_field_split.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_uyvy_field_split
// Self-checking bench for the RGB pair to UYVY field split converter. Pixel
// pairs are offered from a queue under random gaps and random output stalls.
// A shadow model predicts every word (BT.601 bytes, field, word position and
// end of frame) and the monitor compares each field in order. Geometry is
// reprogrammed between phases, including odd, zero and oversized settings.
// ----------------------------------------------------------------------------
module tb_rgb_to_uyvy_field_split import rgbuyvy_pkg::*; ();

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 3;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam logic [IDX_W-1:0] REG_UNUSED_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = IDX_W'(3);

    typedef struct packed {
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] red_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] blue_second;
    } t_rgb_pair;

    typedef struct packed {
        logic [PIX_W-1:0]  chroma_u;
        logic [PIX_W-1:0]  luma_first;
        logic [PIX_W-1:0]  chroma_v;
        logic [PIX_W-1:0]  luma_second;
        logic              odd_field;
        logic [WORD_W-1:0] word_index;
        logic              last_pair;
    } t_uyvy_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [PIX_W-1:0]  i_red_first = '0;
    logic [PIX_W-1:0]  i_green_first = '0;
    logic [PIX_W-1:0]  i_blue_first = '0;
    logic [PIX_W-1:0]  i_red_second = '0;
    logic [PIX_W-1:0]  i_green_second = '0;
    logic [PIX_W-1:0]  i_blue_second = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [PIX_W-1:0]  o_chroma_u;
    logic [PIX_W-1:0]  o_luma_first;
    logic [PIX_W-1:0]  o_chroma_v;
    logic [PIX_W-1:0]  o_luma_second;
    logic              o_odd_field;
    logic [WORD_W-1:0] o_word_index;
    logic              o_last_pair;

    rgb_to_uyvy_field_split i_dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow geometry and position
    logic [CFG_W-1:0]  width_reg = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]  height_reg = FRAME_HEIGHT_RST;
    int                pair_col = 0;
    int                row_num = 0;
    logic [WORD_W-1:0] even_words = '0;
    logic [WORD_W-1:0] odd_words = '0;

    t_rgb_pair  pending_pairs[$];
    t_uyvy_word expected_words[$];
    t_rgb_pair  pair_on_wire;
    t_uyvy_word seen_word;
    t_uyvy_word want_word;

    int fail_count = 0;
    int pairs_accepted = 0;
    int frames_closed = 0;
    int geometry_changes = 0;
    int send_wait = 0;
    int send_burst = 0;
    int recv_wait = 0;
    int recv_burst = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    logic send_next;
    logic stall_next;

    function automatic int pairs_per_row();
        int pairs;
        pairs = (int'(width_reg) + 1) >> 1;
        if (pairs > MAX_WIDTH / 2)
            pairs = MAX_WIDTH / 2;
        if (pairs == 0)
            pairs = 1;
        return pairs;
    endfunction

    function automatic int rows_per_frame();
        int rows;
        rows = int'(height_reg);
        if (rows > MAX_HEIGHT)
            rows = MAX_HEIGHT;
        if (rows == 0)
            rows = 1;
        return rows;
    endfunction

    function automatic logic [PIX_W-1:0] chroma_byte(int kr, int kg, int kb,
                                                     logic [PIX_W-1:0] r,
                                                     logic [PIX_W-1:0] g,
                                                     logic [PIX_W-1:0] b);
        int acc;
        // bias keeps the sum positive, so bits 15:8 hold floor(x / 256) + 128
        acc = kr * int'(r) + kg * int'(g) + kb * int'(b) + 128 + 32768;
        return acc[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] luma_byte(logic [PIX_W-1:0] r,
                                                   logic [PIX_W-1:0] g,
                                                   logic [PIX_W-1:0] b);
        int acc;
        acc = 66 * int'(r) + 129 * int'(g) + 25 * int'(b) + 128;
        return PIX_W'((acc >> 8) + 16);
    endfunction

    function automatic t_uyvy_word convert_pair(t_rgb_pair px);
        t_uyvy_word w;
        logic       row_end;
        row_end = (pair_col + 1 >= pairs_per_row());
        w.chroma_u    = chroma_byte(-38, -74, 112,
                                    px.red_first, px.green_first, px.blue_first);
        w.luma_first  = luma_byte(px.red_first, px.green_first, px.blue_first);
        w.chroma_v    = chroma_byte(112, -94, -18,
                                    px.red_first, px.green_first, px.blue_first);
        w.luma_second = luma_byte(px.red_second, px.green_second, px.blue_second);
        w.odd_field   = row_num[0];
        w.word_index  = w.odd_field ? odd_words : even_words;
        w.last_pair   = row_end && (row_num + 1 >= rows_per_frame());
        if (w.last_pair) begin
            pair_col   = 0;
            row_num    = 0;
            even_words = '0;
            odd_words  = '0;
        end else begin
            if (w.odd_field)
                odd_words = odd_words + 1'b1;
            else
                even_words = even_words + 1'b1;
            if (row_end) begin
                pair_col = 0;
                row_num  = row_num + 1;
            end else begin
                pair_col = pair_col + 1;
            end
        end
        return w;
    endfunction

    // pairs still needed to close the current frame
    function automatic int frame_left();
        int pairs;
        int rows;
        int in_row;
        int rows_after;
        pairs = pairs_per_row();
        rows = rows_per_frame();
        in_row = (pair_col + 1 >= pairs) ? 1 : pairs - pair_col;
        rows_after = (row_num + 1 >= rows) ? 0 : rows - row_num - 1;
        return in_row + rows_after * pairs;
    endfunction

    function automatic int pick_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic t_rgb_pair rand_pair();
        logic [6*PIX_W-1:0] bits;
        int                 k;
        for (k = 0; k < 6; k++) begin
            case ($urandom_range(0, 7))
                0: bits[PIX_W*k +: PIX_W] = '0;
                1: bits[PIX_W*k +: PIX_W] = '1;
                default: bits[PIX_W*k +: PIX_W] = PIX_W'($urandom_range(0, 255));
            endcase
        end
        return t_rgb_pair'(bits);
    endfunction

    function automatic void push_pair(int r0, int g0, int b0, int r1, int g1, int b1);
        t_rgb_pair px;
        px = '{PIX_W'(r0), PIX_W'(g0), PIX_W'(b0), PIX_W'(r1), PIX_W'(g1), PIX_W'(b1)};
        pending_pairs.push_back(px);
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return CFG_W'(1);
            2: return '1;
            3: return CFG_W'(MAX_WIDTH);
            4: return CFG_W'(MAX_WIDTH + 2);
            5: return CFG_W'($urandom_range(0, 2047));
            6: return CFG_W'(2 * $urandom_range(1, 15) + 1);
            default: return CFG_W'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'(1);
            2: return '1;
            3: return CFG_W'(MAX_HEIGHT);
            4: return CFG_W'($urandom_range(0, 2047));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || i_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == REG_FRAME_WIDTH)
            width_reg = data;
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = data;
    endtask

    // new geometry while idle, position carries over
    task automatic reshape_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_FRAME_WIDTH, w);
            write_reg(REG_FRAME_HEIGHT, h);
        end else begin
            write_reg(REG_FRAME_HEIGHT, h);
            write_reg(REG_FRAME_WIDTH, w);
        end
        // out of range index, must be ignored
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                      CFG_W'($urandom_range(0, 2047)));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        geometry_changes++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait = 0;
        end else begin
            send_next = i_valid;
            if (i_valid && !o_stall) begin
                expected_words.push_back(convert_pair(pair_on_wire));
                pairs_accepted++;
                send_wait = pick_wait(send_burst);
                send_next = 1'b0;
            end
            if (!send_next) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_pairs.size() != 0) begin
                    pair_on_wire = pending_pairs.pop_front();
                    i_red_first    <= pair_on_wire.red_first;
                    i_green_first  <= pair_on_wire.green_first;
                    i_blue_first   <= pair_on_wire.blue_first;
                    i_red_second   <= pair_on_wire.red_second;
                    i_green_second <= pair_on_wire.green_second;
                    i_blue_second  <= pair_on_wire.blue_second;
                    send_next = 1'b1;
                end
            end
            i_valid <= send_next;
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                seen_word = '{o_chroma_u, o_luma_first, o_chroma_v, o_luma_second,
                              o_odd_field, o_word_index, o_last_pair};
                if (seen_word.last_pair)
                    frames_closed++;
                if (expected_words.size() == 0) begin
                    $display("%0t ns: word with no request pending, got %h",
                             $time, seen_word);
                    fail_count++;
                end else begin
                    want_word = expected_words.pop_front();
                    if (seen_word.chroma_u !== want_word.chroma_u) begin
                        $display("%0t ns: chroma_u expected %0d, got %0d",
                                 $time, want_word.chroma_u, seen_word.chroma_u);
                        fail_count++;
                    end
                    if (seen_word.luma_first !== want_word.luma_first) begin
                        $display("%0t ns: luma_first expected %0d, got %0d",
                                 $time, want_word.luma_first, seen_word.luma_first);
                        fail_count++;
                    end
                    if (seen_word.chroma_v !== want_word.chroma_v) begin
                        $display("%0t ns: chroma_v expected %0d, got %0d",
                                 $time, want_word.chroma_v, seen_word.chroma_v);
                        fail_count++;
                    end
                    if (seen_word.luma_second !== want_word.luma_second) begin
                        $display("%0t ns: luma_second expected %0d, got %0d",
                                 $time, want_word.luma_second, seen_word.luma_second);
                        fail_count++;
                    end
                    if (seen_word.odd_field !== want_word.odd_field) begin
                        $display("%0t ns: odd_field expected %0d, got %0d",
                                 $time, want_word.odd_field, seen_word.odd_field);
                        fail_count++;
                    end
                    if (seen_word.word_index !== want_word.word_index) begin
                        $display("%0t ns: word_index expected %0d, got %0d",
                                 $time, want_word.word_index, seen_word.word_index);
                        fail_count++;
                    end
                    if (seen_word.last_pair !== want_word.last_pair) begin
                        $display("%0t ns: last_pair expected %0d, got %0d",
                                 $time, want_word.last_pair, seen_word.last_pair);
                        fail_count++;
                    end
                end
                recv_wait = pick_wait(recv_burst);
            end
            stall_next = (recv_wait > 0) || (hold_left != 0);
            if (recv_wait > 0)
                recv_wait--;
            i_stall <= stall_next;
        end
    end

    initial begin : stimulus
        int n;
        int phase;
        int random_pairs;
        random_pairs = 0;
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // color extremes under the reset geometry
        push_pair(0, 0, 0, 0, 0, 0);
        push_pair(255, 255, 255, 255, 255, 255);
        push_pair(255, 0, 0, 0, 255, 0);
        push_pair(0, 0, 255, 255, 255, 255);
        push_pair(255, 255, 0, 0, 0, 0);
        push_pair(0, 255, 255, 0, 0, 255);
        push_pair(255, 0, 0, 255, 0, 255);
        push_pair(8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA);
        push_pair(8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55);
        push_pair(8'h0F, 8'hF0, 8'h0F, 8'hF0, 8'h0F, 8'hF0);
        push_pair(8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F);
        push_pair(1, 254, 128, 127, 2, 253);

        // odd width, zero height, shrunk below the current column
        reshape_frame(CFG_W'(5), '0);
        repeat (5) pending_pairs.push_back(rand_pair());
        // zero width gives one pair per row
        reshape_frame('0, CFG_W'(2));
        repeat (4) pending_pairs.push_back(rand_pair());

        for (phase = 0; phase < 8 || random_pairs < 1500; phase++) begin
            if (phase == 2) begin
                // oversized width, receiver holds off while rows keep coming
                reshape_frame('1, CFG_W'(1));
                n = frame_left() + 3;
                hold_requests++;
            end else if (phase == 5) begin
                // oversized height walks all rows of the frame
                reshape_frame(CFG_W'(1), '1);
                n = frame_left() + 2;
            end else begin
                reshape_frame(pick_width(), pick_height());
                n = frame_left();
                if (n > 40)
                    n = $urandom_range(6, 40);
                else
                    n = n + $urandom_range(0, n);
            end
            repeat (n) pending_pairs.push_back(rand_pair());
            random_pairs += n;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_words.size() != 0) begin
            $display("%0t ns: %0d words never arrived", $time, expected_words.size());
            fail_count++;
        end
        $display("converted %0d pixel pairs across %0d geometry settings", pairs_accepted,
                 geometry_changes);
        $display("%0d frames closed, %0d field errors", frames_closed, fail_count);
        if (fail_count == 0)
            $display("rgb_to_uyvy_field_split: match");
        else
            $display("rgb_to_uyvy_field_split: mismatch");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t ns: timeout", $time);
        $display("rgb_to_uyvy_field_split: mismatch");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rgbuyvy_pkg.sv
hw/rtl/rgbuyvy_luma.sv
hw/rtl/rgbuyvy_chroma.sv
hw/rtl/rgbuyvy_pos.sv
hw/rtl/rgb_to_uyvy_field_split.sv
bench/tb_rgb_to_uyvy_field_split.sv
